@@ rtl/acds_pkg.sv @@
// ----------------------------------------------------------------------------
// acds_pkg: shared types, constants and microprogram for the duty step unit
// Holds the Q16.16 wide-value type, the saturation helper, the request and
// response structs of the multiply-divide unit and the sequencer's program.
// ----------------------------------------------------------------------------
package acds_pkg;

    localparam int WW   = 49;          // wide intermediate: +-2^47 plus sign
    localparam int MAGW = WW - 1;      // magnitude width of a wide value
    localparam int PCW  = 7;           // program counter width

    typedef logic signed [WW-1:0] wide_t;

    localparam wide_t CLIM     = wide_t'(64'sd140737488355328);
    localparam wide_t CLIM_NEG = -CLIM;
    localparam wide_t TOL_W    = wide_t'(66);
    localparam wide_t TOL_NEG  = -TOL_W;
    localparam wide_t HUND_W   = wide_t'(6553600);
    localparam wide_t HUND_TOL = wide_t'(6553600 + 66);
    localparam wide_t CEIL_W   = wide_t'(64'sd65536000000);
    localparam wide_t I32MAX   = wide_t'(64'sd2147483647);
    localparam wide_t I32MIN   = wide_t'(-64'sd2147483648);

    // Configuration register indexes.
    localparam logic [2:0] REG_GAIN_OWN   = 3'd0;
    localparam logic [2:0] REG_GAIN_OTHER = 3'd1;
    localparam logic [2:0] REG_PENALTY    = 3'd2;
    localparam logic [2:0] REG_ENERGY     = 3'd3;
    localparam logic [2:0] REG_TARGET     = 3'd4;

    // Item kinds.
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_ITER   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_HALF, OP_CL32, OP_MUL, OP_DIV, OP_CHK, OP_TAKE,
        OP_OVR, OP_CALL, OP_BRT, OP_BRLE, OP_DONE
    } op_t;

    typedef enum logic [5:0] {
        S_ZERO, S_K0, S_K1, S_RHO, S_EC, S_HUND, S_TOL, S_CEIL,
        S_AVG0, S_AVG1, S_MUL0, S_MUL1, S_EXT, S_TGT, S_BEST0, S_BEST1,
        S_CP0, S_CP1, S_PRV0, S_PRV1, S_EXTIN, S_TCFG,
        S_M, S_N, S_Z1, S_Z2, S_U1, S_U2, S_OL, S_NEED, S_BASE,
        S_D1, S_D2, S_X, S_Y, S_T, S_C
    } src_t;

    typedef enum logic [4:0] {
        D_NONE, D_AVG0, D_AVG1, D_MUL0, D_MUL1, D_EXT, D_TGT,
        D_M, D_N, D_Z1, D_Z2, D_U1, D_U2, D_OL, D_NEED, D_BASE,
        D_D1, D_D2, D_X, D_Y, D_T, D_C, D_CBEST, D_REF
    } dst_t;

    typedef struct packed {
        op_t            op;
        dst_t           dst;
        src_t           a;
        src_t           b;
        logic [PCW-1:0] jmp;
    } uinst_t;

    typedef struct packed {
        logic  start;
        logic  div;
        wide_t a;
        wide_t b;
    } mdu_req_t;

    typedef struct packed {
        logic  done;
        wide_t res;
    } mdu_rsp_t;

    // Program entry points and branch targets.
    localparam logic [PCW-1:0] PC_START  = 7'd0;
    localparam logic [PCW-1:0] PC_FINISH = 7'd9;
    localparam logic [PCW-1:0] PC_NOP    = 7'd12;
    localparam logic [PCW-1:0] PC_ITER   = 7'd13;
    localparam logic [PCW-1:0] PC_CAND4  = 7'd52;
    localparam logic [PCW-1:0] PC_UPD    = 7'd70;
    localparam logic [PCW-1:0] PC_TRY    = 7'd83;

    function automatic wide_t clampw(logic signed [WW:0] x);
        wide_t r;
        if (x > $signed({CLIM[WW-1], CLIM}))
            r = CLIM;
        else if (x < $signed({CLIM_NEG[WW-1], CLIM_NEG}))
            r = CLIM_NEG;
        else
            r = x[WW-1:0];
        return r;
    endfunction

    function automatic uinst_t mk(op_t op, dst_t d, src_t a, src_t b,
                                  logic [PCW-1:0] j);
        uinst_t u;
        u.op  = op;
        u.dst = d;
        u.a   = a;
        u.b   = b;
        u.jmp = j;
        return u;
    endfunction

    function automatic uinst_t acds_ucode(logic [PCW-1:0] pc);
        uinst_t u;
        case (pc)
            // Start item.
            7'd0:   u = mk(OP_ADD,  D_X,    S_PRV0, S_CP0,  '0);
            7'd1:   u = mk(OP_HALF, D_AVG0, S_X,    S_ZERO, '0);
            7'd2:   u = mk(OP_ADD,  D_X,    S_PRV1, S_CP1,  '0);
            7'd3:   u = mk(OP_HALF, D_AVG1, S_X,    S_ZERO, '0);
            7'd4:   u = mk(OP_ADD,  D_MUL0, S_ZERO, S_ZERO, '0);
            7'd5:   u = mk(OP_ADD,  D_MUL1, S_ZERO, S_ZERO, '0);
            7'd6:   u = mk(OP_ADD,  D_EXT,  S_EXTIN, S_ZERO, '0);
            7'd7:   u = mk(OP_ADD,  D_TGT,  S_TCFG, S_ZERO, '0);
            7'd8:   u = mk(OP_DONE, D_NONE, S_ZERO, S_ZERO, '0);
            // Finish item.
            7'd9:   u = mk(OP_OVR,  D_NONE, S_ZERO, S_ZERO, '0);
            7'd10:  u = mk(OP_MUL,  D_X,    S_K0,   S_BEST0, '0);
            7'd11:  u = mk(OP_CL32, D_REF,  S_X,    S_ZERO, '0);
            7'd12:  u = mk(OP_DONE, D_NONE, S_ZERO, S_ZERO, '0);
            // Iterate item: common terms.
            7'd13:  u = mk(OP_MUL,  D_X,    S_K0,   S_K0,   '0);
            7'd14:  u = mk(OP_MUL,  D_N,    S_K1,   S_K1,   '0);
            7'd15:  u = mk(OP_ADD,  D_M,    S_X,    S_N,    '0);
            7'd16:  u = mk(OP_MUL,  D_X,    S_RHO,  S_AVG0, '0);
            7'd17:  u = mk(OP_SUB,  D_X,    S_X,    S_EC,   '0);
            7'd18:  u = mk(OP_SUB,  D_Z1,   S_X,    S_MUL0, '0);
            7'd19:  u = mk(OP_MUL,  D_X,    S_RHO,  S_AVG1, '0);
            7'd20:  u = mk(OP_SUB,  D_Z2,   S_X,    S_MUL1, '0);
            7'd21:  u = mk(OP_DIV,  D_U1,   S_Z1,   S_RHO,  '0);
            7'd22:  u = mk(OP_DIV,  D_U2,   S_Z2,   S_RHO,  '0);
            7'd23:  u = mk(OP_SUB,  D_OL,   S_EXT,  S_TGT,  '0);
            7'd24:  u = mk(OP_SUB,  D_X,    S_TGT,  S_EXT,  '0);
            7'd25:  u = mk(OP_SUB,  D_NEED, S_X,    S_TOL,  '0);
            7'd26:  u = mk(OP_ADD,  D_CBEST, S_CEIL, S_ZERO, '0);
            // Unconstrained minimum.
            7'd27:  u = mk(OP_CL32, D_D1,   S_U1,   S_ZERO, '0);
            7'd28:  u = mk(OP_CL32, D_D2,   S_U2,   S_ZERO, '0);
            7'd29:  u = mk(OP_CALL, D_NONE, S_ZERO, S_ZERO, '0);
            7'd30:  u = mk(OP_BRT,  D_NONE, S_ZERO, S_ZERO, PC_UPD);
            // Lower and upper dimming bounds.
            7'd31:  u = mk(OP_CL32, D_D1,   S_ZERO, S_ZERO, '0);
            7'd32:  u = mk(OP_CL32, D_D2,   S_U2,   S_ZERO, '0);
            7'd33:  u = mk(OP_CALL, D_NONE, S_ZERO, S_ZERO, '0);
            7'd34:  u = mk(OP_CL32, D_D1,   S_HUND, S_ZERO, '0);
            7'd35:  u = mk(OP_CL32, D_D2,   S_U2,   S_ZERO, '0);
            7'd36:  u = mk(OP_CALL, D_NONE, S_ZERO, S_ZERO, '0);
            // Illuminance bound.
            7'd37:  u = mk(OP_BRLE, D_NONE, S_M,    S_ZERO, PC_CAND4);
            7'd38:  u = mk(OP_MUL,  D_X,    S_K0,   S_Z1,   '0);
            7'd39:  u = mk(OP_MUL,  D_Y,    S_K1,   S_Z2,   '0);
            7'd40:  u = mk(OP_ADD,  D_X,    S_X,    S_Y,    '0);
            7'd41:  u = mk(OP_DIV,  D_X,    S_X,    S_RHO,  '0);
            7'd42:  u = mk(OP_ADD,  D_X,    S_OL,   S_X,    '0);
            7'd43:  u = mk(OP_MUL,  D_Y,    S_K0,   S_X,    '0);
            7'd44:  u = mk(OP_DIV,  D_Y,    S_Y,    S_M,    '0);
            7'd45:  u = mk(OP_SUB,  D_Y,    S_U1,   S_Y,    '0);
            7'd46:  u = mk(OP_CL32, D_D1,   S_Y,    S_ZERO, '0);
            7'd47:  u = mk(OP_MUL,  D_Y,    S_K1,   S_X,    '0);
            7'd48:  u = mk(OP_DIV,  D_Y,    S_Y,    S_M,    '0);
            7'd49:  u = mk(OP_SUB,  D_Y,    S_U2,   S_Y,    '0);
            7'd50:  u = mk(OP_CL32, D_D2,   S_Y,    S_ZERO, '0);
            7'd51:  u = mk(OP_CALL, D_NONE, S_ZERO, S_ZERO, '0);
            // Corners.
            7'd52:  u = mk(OP_BRLE, D_NONE, S_N,    S_ZERO, PC_UPD);
            7'd53:  u = mk(OP_MUL,  D_X,    S_K1,   S_OL,   '0);
            7'd54:  u = mk(OP_MUL,  D_Y,    S_N,    S_Z2,   '0);
            7'd55:  u = mk(OP_DIV,  D_Y,    S_Y,    S_RHO,  '0);
            7'd56:  u = mk(OP_ADD,  D_BASE, S_X,    S_Y,    '0);
            7'd57:  u = mk(OP_DIV,  D_Y,    S_BASE, S_N,    '0);
            7'd58:  u = mk(OP_SUB,  D_Y,    S_U2,   S_Y,    '0);
            7'd59:  u = mk(OP_CL32, D_D2,   S_Y,    S_ZERO, '0);
            7'd60:  u = mk(OP_CL32, D_D1,   S_ZERO, S_ZERO, '0);
            7'd61:  u = mk(OP_CALL, D_NONE, S_ZERO, S_ZERO, '0);
            7'd62:  u = mk(OP_MUL,  D_X,    S_K1,   S_K0,   '0);
            7'd63:  u = mk(OP_MUL,  D_X,    S_X,    S_HUND, '0);
            7'd64:  u = mk(OP_ADD,  D_X,    S_BASE, S_X,    '0);
            7'd65:  u = mk(OP_DIV,  D_Y,    S_X,    S_N,    '0);
            7'd66:  u = mk(OP_SUB,  D_Y,    S_U2,   S_Y,    '0);
            7'd67:  u = mk(OP_CL32, D_D2,   S_Y,    S_ZERO, '0);
            7'd68:  u = mk(OP_CL32, D_D1,   S_HUND, S_ZERO, '0);
            7'd69:  u = mk(OP_CALL, D_NONE, S_ZERO, S_ZERO, '0);
            // Averages and multipliers.
            7'd70:  u = mk(OP_ADD,  D_X,    S_BEST0, S_CP0, '0);
            7'd71:  u = mk(OP_HALF, D_AVG0, S_X,    S_ZERO, '0);
            7'd72:  u = mk(OP_ADD,  D_X,    S_BEST1, S_CP1, '0);
            7'd73:  u = mk(OP_HALF, D_AVG1, S_X,    S_ZERO, '0);
            7'd74:  u = mk(OP_SUB,  D_X,    S_BEST0, S_AVG0, '0);
            7'd75:  u = mk(OP_MUL,  D_X,    S_RHO,  S_X,    '0);
            7'd76:  u = mk(OP_ADD,  D_X,    S_MUL0, S_X,    '0);
            7'd77:  u = mk(OP_CL32, D_MUL0, S_X,    S_ZERO, '0);
            7'd78:  u = mk(OP_SUB,  D_X,    S_BEST1, S_AVG1, '0);
            7'd79:  u = mk(OP_MUL,  D_X,    S_RHO,  S_X,    '0);
            7'd80:  u = mk(OP_ADD,  D_X,    S_MUL1, S_X,    '0);
            7'd81:  u = mk(OP_CL32, D_MUL1, S_X,    S_ZERO, '0);
            7'd82:  u = mk(OP_DONE, D_NONE, S_ZERO, S_ZERO, '0);
            // Candidate subroutine: feasibility, then cost and selection.
            7'd83:  u = mk(OP_MUL,  D_X,    S_K0,   S_D1,   '0);
            7'd84:  u = mk(OP_MUL,  D_Y,    S_K1,   S_D2,   '0);
            7'd85:  u = mk(OP_ADD,  D_X,    S_X,    S_Y,    '0);
            7'd86:  u = mk(OP_CHK,  D_NONE, S_X,    S_ZERO, '0);
            7'd87:  u = mk(OP_SUB,  D_X,    S_D1,   S_AVG0, '0);
            7'd88:  u = mk(OP_SUB,  D_Y,    S_D2,   S_AVG1, '0);
            7'd89:  u = mk(OP_MUL,  D_C,    S_EC,   S_D1,   '0);
            7'd90:  u = mk(OP_MUL,  D_T,    S_MUL0, S_X,    '0);
            7'd91:  u = mk(OP_ADD,  D_C,    S_C,    S_T,    '0);
            7'd92:  u = mk(OP_MUL,  D_T,    S_MUL1, S_Y,    '0);
            7'd93:  u = mk(OP_ADD,  D_C,    S_C,    S_T,    '0);
            7'd94:  u = mk(OP_MUL,  D_T,    S_X,    S_X,    '0);
            7'd95:  u = mk(OP_MUL,  D_X,    S_Y,    S_Y,    '0);
            7'd96:  u = mk(OP_ADD,  D_X,    S_T,    S_X,    '0);
            7'd97:  u = mk(OP_MUL,  D_X,    S_RHO,  S_X,    '0);
            7'd98:  u = mk(OP_HALF, D_X,    S_X,    S_ZERO, '0);
            7'd99:  u = mk(OP_ADD,  D_C,    S_C,    S_X,    '0);
            7'd100: u = mk(OP_TAKE, D_NONE, S_ZERO, S_ZERO, '0);
            default: u = mk(OP_DONE, D_NONE, S_ZERO, S_ZERO, '0);
        endcase
        return u;
    endfunction

endpackage

@@ rtl/acds_mdu.sv @@
// ----------------------------------------------------------------------------
// acds_mdu: shared bit-serial multiply and divide unit
// Multiplies two wide Q16.16 values one bit a cycle, or divides a wide value
// shifted left by 16 by a positive one, one quotient bit a cycle; saturates.
// ----------------------------------------------------------------------------
module acds_mdu
(
    input  logic               clk,
    input  logic               rst_n,
    input  acds_pkg::mdu_req_t req,
    output acds_pkg::mdu_rsp_t rsp
);
    import acds_pkg::*;

    localparam int PW = 2 * MAGW;
    localparam int QW = MAGW + 16;
    localparam logic [6:0] MUL_STEPS = 7'(MAGW);
    localparam logic [6:0] DIV_STEPS = 7'(QW);
    localparam logic [PW-17:0] CLIM_MAG = (PW-16)'(CLIM);

    logic            busy_reg;
    logic            done_reg;
    logic [6:0]      cnt_reg;
    logic            div_reg;
    logic            neg_reg;
    logic [MAGW-1:0] opd_reg;
    logic [PW-1:0]   prod_reg;
    logic [QW-1:0]   quo_reg;
    logic [MAGW-1:0] rem_reg;

    logic [MAGW:0]   msum;
    logic [MAGW:0]   rtrial;
    logic [MAGW:0]   rdiff;
    logic            rge;
    logic [PW-17:0]  mag;
    logic [WW-1:0]   resmag;

    function automatic logic [MAGW-1:0] magof(wide_t v);
        wide_t n;
        n = -v;
        return v[WW-1] ? n[MAGW-1:0] : v[MAGW-1:0];
    endfunction

    always_comb
    begin
        msum   = {1'b0, prod_reg[PW-1:MAGW]} + (prod_reg[0] ? {1'b0, opd_reg} : '0);
        rtrial = {rem_reg, quo_reg[QW-1]};
        rge    = rtrial >= {1'b0, opd_reg};
        rdiff  = rtrial - {1'b0, opd_reg};
        mag    = div_reg ? (PW-16)'(quo_reg) : prod_reg[PW-1:16];
        resmag = (mag > CLIM_MAG) ? CLIM : mag[WW-1:0];
        rsp.done = done_reg;
        rsp.res  = neg_reg ? -$signed(resmag) : $signed(resmag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.div ? DIV_STEPS : MUL_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg <= req.div;
            if (req.div)
            begin
                neg_reg <= req.a[WW-1];
                opd_reg <= magof(req.b);
                quo_reg <= {magof(req.a), 16'b0};
                rem_reg <= '0;
            end
            else
            begin
                neg_reg  <= req.a[WW-1] ^ req.b[WW-1];
                opd_reg  <= magof(req.a);
                prod_reg <= {{MAGW{1'b0}}, magof(req.b)};
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_reg <= rge ? rdiff[MAGW-1:0] : rtrial[MAGW-1:0];
                quo_reg <= {quo_reg[QW-2:0], rge};
            end
            else
            begin
                prod_reg <= {msum, prod_reg[MAGW-1:1]};
            end
        end
    end

endmodule

@@ rtl/admm_consensus_duty_step_unit.sv @@
// ----------------------------------------------------------------------------
// admm_consensus_duty_step_unit: local step of two-node ADMM lamp consensus
// Microcoded sequencer around one bit-serial multiply-divide unit.
// ----------------------------------------------------------------------------
// The unit takes one word at a time and returns exactly one result word for
// each. A start word sets the consensus averages from the node's own and the
// neighbour's duties, clears the multipliers and captures the external lux
// and the target. An iterate word tries the unconstrained minimum and then
// the bound and corner candidates, keeps the feasible one of least
// augmented-Lagrangian cost and updates averages and multipliers. A finish
// word applies the all-at-100 override and returns the reference lux. All
// arithmetic is Q16.16 on 49-bit saturating intermediates. Every product and
// quotient goes through one shared bit-serial unit. How long an iterate word
// runs depends on how many candidates are feasible and whether the coupling
// gains are zero. The input is ready only while the sequencer is idle; a
// finished result sits in an output register, so the next word can be taken
// while the previous result is still waiting downstream. Configuration must
// be written only while the unit is idle, which the unit itself does not
// enforce; it is not read back.
// ----------------------------------------------------------------------------
module admm_consensus_duty_step_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // copy_own[31:0], copy_other[63:32], prev_own[95:64], prev_other[127:96],
    // ext_lux[159:128]
    input  logic [159:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // duty_own[31:0], duty_other[63:32], ref_lux[95:64]
    output logic [95:0]  m_axis_tdata,
    // over_max[0]
    output logic         m_axis_tuser
);
    import acds_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [PCW-1:0] pc_reg, pc_next, ret_reg, ret_next;
    logic taken_reg, taken_next, over_reg, over_next;

    // Configuration registers.
    logic [30:0] gain_own_reg, gain_other_reg, penalty_reg, energy_reg, target_reg;

    // Persistent state.
    logic [31:0] avg0_reg, avg1_reg, mul0_reg, mul1_reg, ext_reg, tgt_reg;
    logic [31:0] best0_reg, best1_reg, best0_next, best1_next, ref_reg;

    // Captured input word.
    logic [31:0] cp0_reg, cp1_reg, prv0_reg, prv1_reg, extin_reg;

    // Working registers of the sequencer.
    wide_t m_reg, n_reg, z1_reg, z2_reg, u1_reg, u2_reg, ol_reg, need_reg;
    wide_t base_reg, d1_reg, d2_reg, x_reg, y_reg, t_reg, c_reg, cbest_reg;

    // Output register.
    logic        mval_reg;
    logic [31:0] out_own_reg, out_other_reg, out_ref_reg;
    logic        out_over_reg;

    uinst_t   ui;
    wide_t    opa, opb, alu_res, wb_val, half_tmp;
    logic signed [WW:0] sum_w, dif_w, half_w;
    logic     wb_en, accept;
    mdu_req_t req;
    mdu_rsp_t rsp;

    function automatic wide_t sx32(logic [31:0] v);
        return {{(WW-32){v[31]}}, v};
    endfunction

    function automatic wide_t zx31(logic [30:0] v);
        return {{(WW-31){1'b0}}, v};
    endfunction

    function automatic wide_t pick(src_t s);
        wide_t r;
        case (s)
            S_ZERO:  r = '0;
            S_K0:    r = zx31(gain_own_reg);
            S_K1:    r = zx31(gain_other_reg);
            S_RHO:   r = (penalty_reg == '0) ? wide_t'(1) : zx31(penalty_reg);
            S_EC:    r = zx31(energy_reg);
            S_HUND:  r = HUND_W;
            S_TOL:   r = TOL_W;
            S_CEIL:  r = CEIL_W;
            S_AVG0:  r = sx32(avg0_reg);
            S_AVG1:  r = sx32(avg1_reg);
            S_MUL0:  r = sx32(mul0_reg);
            S_MUL1:  r = sx32(mul1_reg);
            S_EXT:   r = sx32(ext_reg);
            S_TGT:   r = sx32(tgt_reg);
            S_BEST0: r = sx32(best0_reg);
            S_BEST1: r = sx32(best1_reg);
            S_CP0:   r = sx32(cp0_reg);
            S_CP1:   r = sx32(cp1_reg);
            S_PRV0:  r = sx32(prv0_reg);
            S_PRV1:  r = sx32(prv1_reg);
            S_EXTIN: r = sx32(extin_reg);
            S_TCFG:  r = zx31(target_reg);
            S_M:     r = m_reg;
            S_N:     r = n_reg;
            S_Z1:    r = z1_reg;
            S_Z2:    r = z2_reg;
            S_U1:    r = u1_reg;
            S_U2:    r = u2_reg;
            S_OL:    r = ol_reg;
            S_NEED:  r = need_reg;
            S_BASE:  r = base_reg;
            S_D1:    r = d1_reg;
            S_D2:    r = d2_reg;
            S_X:     r = x_reg;
            S_Y:     r = y_reg;
            S_T:     r = t_reg;
            S_C:     r = c_reg;
            default: r = '0;
        endcase
        return r;
    endfunction

    acds_mdu u_mdu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = {out_ref_reg, out_other_reg, out_own_reg};
    assign m_axis_tuser  = out_over_reg;

    // Operand fetch and combinational arithmetic.
    always_comb
    begin
        ui       = acds_ucode(pc_reg);
        opa      = pick(ui.a);
        opb      = pick(ui.b);
        sum_w    = {opa[WW-1], opa} + {opb[WW-1], opb};
        dif_w    = {opa[WW-1], opa} - {opb[WW-1], opb};
        // Halving truncates toward zero, as a signed divide by two does.
        half_w   = {opa[WW-1], opa} + (WW+1)'(opa[WW-1]);
        half_tmp = half_w[WW:1];
        case (ui.op)
            OP_ADD:  alu_res = clampw(sum_w);
            OP_SUB:  alu_res = clampw(dif_w);
            OP_HALF: alu_res = half_tmp;
            OP_CL32: alu_res = (opa > I32MAX) ? I32MAX : ((opa < I32MIN) ? I32MIN : opa);
            default: alu_res = opa;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        ret_next   = ret_reg;
        taken_next = taken_reg;
        over_next  = over_reg;
        best0_next = best0_reg;
        best1_next = best1_reg;
        wb_en      = 1'b0;
        wb_val     = alu_res;
        req.start  = 1'b0;
        req.div    = (ui.op == OP_DIV);
        req.a      = opa;
        req.b      = opb;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                    case (s_axis_tuser)
                        KIND_START:  pc_next = PC_START;
                        KIND_ITER:   pc_next = PC_ITER;
                        KIND_FINISH: pc_next = PC_FINISH;
                        default:     pc_next = PC_NOP;
                    endcase
                end
            end
            ST_EXEC:
            begin
                pc_next = pc_reg + 7'd1;
                case (ui.op)
                    OP_ADD, OP_SUB, OP_HALF, OP_CL32:
                    begin
                        wb_en = 1'b1;
                    end
                    OP_MUL, OP_DIV:
                    begin
                        req.start  = 1'b1;
                        pc_next    = pc_reg;
                        state_next = ST_WAIT;
                    end
                    OP_CHK:
                    begin
                        // A lower or illuminance violation clears the flag,
                        // an upper violation sets it; either ends the try.
                        if (d1_reg < TOL_NEG || opa < need_reg)
                        begin
                            over_next  = 1'b0;
                            taken_next = 1'b0;
                            pc_next    = ret_reg;
                        end
                        else if (d1_reg > HUND_TOL)
                        begin
                            over_next  = 1'b1;
                            taken_next = 1'b0;
                            pc_next    = ret_reg;
                        end
                    end
                    OP_TAKE:
                    begin
                        pc_next    = ret_reg;
                        taken_next = (c_reg < cbest_reg);
                        if (c_reg < cbest_reg)
                        begin
                            best0_next = d1_reg[31:0];
                            best1_next = d2_reg[31:0];
                        end
                    end
                    OP_OVR:
                    begin
                        if (over_reg)
                        begin
                            best0_next = HUND_W[31:0];
                            best1_next = HUND_W[31:0];
                        end
                    end
                    OP_CALL:
                    begin
                        ret_next = pc_reg + 7'd1;
                        pc_next  = PC_TRY;
                    end
                    OP_BRT:
                    begin
                        if (taken_reg)
                        begin
                            pc_next = ui.jmp;
                        end
                    end
                    OP_BRLE:
                    begin
                        if (opa <= 0)
                        begin
                            pc_next = ui.jmp;
                        end
                    end
                    default:
                    begin
                        pc_next    = pc_reg;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    wb_en      = 1'b1;
                    wb_val     = rsp.res;
                    pc_next    = pc_reg + 7'd1;
                    state_next = ST_EXEC;
                end
            end
            ST_DONE:
            begin
                if (!mval_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, configuration and persistent state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pc_reg         <= '0;
            ret_reg        <= '0;
            taken_reg      <= 1'b0;
            over_reg       <= 1'b0;
            best0_reg      <= '0;
            best1_reg      <= '0;
            avg0_reg       <= '0;
            avg1_reg       <= '0;
            mul0_reg       <= '0;
            mul1_reg       <= '0;
            ext_reg        <= '0;
            tgt_reg        <= '0;
            mval_reg       <= 1'b0;
            gain_own_reg   <= 31'd65536;
            gain_other_reg <= 31'd0;
            penalty_reg    <= 31'd65536;
            energy_reg     <= 31'd65536;
            target_reg     <= 31'd0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            ret_reg   <= ret_next;
            taken_reg <= taken_next;
            over_reg  <= over_next;
            best0_reg <= best0_next;
            best1_reg <= best1_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_OWN:   gain_own_reg   <= cfg_data;
                    REG_GAIN_OTHER: gain_other_reg <= cfg_data;
                    REG_PENALTY:    penalty_reg    <= cfg_data;
                    REG_ENERGY:     energy_reg     <= cfg_data;
                    REG_TARGET:     target_reg     <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (wb_en)
            begin
                case (ui.dst)
                    D_AVG0: avg0_reg <= wb_val[31:0];
                    D_AVG1: avg1_reg <= wb_val[31:0];
                    D_MUL0: mul0_reg <= wb_val[31:0];
                    D_MUL1: mul1_reg <= wb_val[31:0];
                    D_EXT:  ext_reg  <= wb_val[31:0];
                    D_TGT:  tgt_reg  <= wb_val[31:0];
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_DONE && (!mval_reg || m_axis_tready))
            begin
                mval_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                mval_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cp0_reg   <= s_axis_tdata[31:0];
            cp1_reg   <= s_axis_tdata[63:32];
            prv0_reg  <= s_axis_tdata[95:64];
            prv1_reg  <= s_axis_tdata[127:96];
            extin_reg <= s_axis_tdata[159:128];
            ref_reg   <= '0;
        end
        if (wb_en)
        begin
            case (ui.dst)
                D_M:     m_reg     <= wb_val;
                D_N:     n_reg     <= wb_val;
                D_Z1:    z1_reg    <= wb_val;
                D_Z2:    z2_reg    <= wb_val;
                D_U1:    u1_reg    <= wb_val;
                D_U2:    u2_reg    <= wb_val;
                D_OL:    ol_reg    <= wb_val;
                D_NEED:  need_reg  <= wb_val;
                D_BASE:  base_reg  <= wb_val;
                D_D1:    d1_reg    <= wb_val;
                D_D2:    d2_reg    <= wb_val;
                D_X:     x_reg     <= wb_val;
                D_Y:     y_reg     <= wb_val;
                D_T:     t_reg     <= wb_val;
                D_C:     c_reg     <= wb_val;
                D_CBEST: cbest_reg <= wb_val;
                D_REF:   ref_reg   <= wb_val[31:0];
                default:
                begin
                end
            endcase
        end
        else if (state_reg == ST_EXEC && ui.op == OP_TAKE && c_reg < cbest_reg)
        begin
            cbest_reg <= c_reg;
        end
        if (state_reg == ST_DONE && (!mval_reg || m_axis_tready))
        begin
            out_own_reg   <= best0_reg;
            out_other_reg <= best1_reg;
            out_ref_reg   <= ref_reg;
            out_over_reg  <= over_reg;
        end
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ADMM consensus duty step unit
// Drives start, iterate and finish words through the input stream under
// several register settings, predicts each result word in Q16.16 and
// compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import acds_pkg::*;

    // Kind code that the unit must treat as a no-op.
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // Fixed-point constants, in raw Q16.16 on 64-bit values.
    localparam longint W_LIM     = 64'sd140737488355328;
    localparam longint Q_TOL     = 64'sd66;
    localparam longint Q_HUNDRED = 64'sd6553600;
    localparam longint Q_CEIL    = 64'sd65536000000;
    localparam longint Q_ONE     = 64'sd65536;

    localparam int RUN_ITEMS = 950;
    localparam int N_PHASES  = 8;

    typedef struct {
        logic signed [31:0] own;
        logic signed [31:0] other;
        logic               over;
        logic signed [31:0] lux;
    } duty_word_t;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] cp_own;
        logic signed [31:0] cp_other;
        logic signed [31:0] pv_own;
        logic signed [31:0] pv_other;
        logic signed [31:0] ext;
        bit                 typed;
        duty_word_t         want;
    } plan_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [30:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;

    admm_consensus_duty_step_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor state: the lamp node's own copy of registers and consensus
    // variables, kept in 64-bit signed values so that saturation to the wide
    // range can be applied explicitly.
    // ------------------------------------------------------------------------
    longint k_own, k_other, rho_cfg, e_cost, lux_target;
    longint avg0, avg1, lam0, lam1, pick0, pick1, ext_h, tgt_h;
    bit     upper_hit;
    longint cost_floor;

    duty_word_t duty_pending[$];
    int         errors;
    int         words_sent;
    int         words_seen;
    int         over_seen;

    function automatic longint sat_w(longint x);
        return x > W_LIM ? W_LIM : (x < -W_LIM ? -W_LIM : x);
    endfunction

    function automatic longint sat_32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint q_add(longint a, longint b);
        return sat_w(sat_w(a) + sat_w(b));
    endfunction

    function automatic longint q_sub(longint a, longint b);
        return sat_w(sat_w(a) - sat_w(b));
    endfunction

    // Product truncated toward zero, saturated to the wide range.
    function automatic longint q_mul(longint a, longint b);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned p;
        a = sat_w(a);
        b = sat_w(b);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        if (ua != 0 && ub > (64'h8000_0000_0000_0000 / ua))
            p = W_LIM;
        else
            p = (ua * ub) >> 16;
        if (p > W_LIM)
            p = W_LIM;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // Quotient for a strictly positive divisor.
    function automatic longint q_div(longint a, longint b);
        longint unsigned ua;
        longint unsigned q;
        a = sat_w(a);
        ua = (a < 0) ? -a : a;
        q = (ua << 16) / longint'(b);
        if (q > W_LIM)
            q = W_LIM;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint rho_now();
        return (rho_cfg == 0) ? 64'sd1 : rho_cfg;
    endfunction

    // Illuminance and dimming bound check; a failure records which bound.
    function automatic bit duty_feasible(longint d1, longint d2);
        longint illum;
        longint need;
        illum = q_add(q_mul(k_own, d1), q_mul(k_other, d2));
        need  = q_sub(q_sub(tgt_h, ext_h), Q_TOL);
        if (d1 < -Q_TOL || illum < need)
        begin
            upper_hit = 1'b0;
            return 1'b0;
        end
        if (d1 > Q_HUNDRED + Q_TOL)
        begin
            upper_hit = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic longint lagrangian(longint d1, longint d2);
        longint e0;
        longint e1;
        longint c;
        longint sq;
        e0 = q_sub(d1, avg0);
        e1 = q_sub(d2, avg1);
        c  = q_mul(e_cost, d1);
        c  = q_add(c, q_mul(lam0, e0));
        c  = q_add(c, q_mul(lam1, e1));
        sq = q_add(q_mul(e0, e0), q_mul(e1, e1));
        return q_add(c, q_mul(rho_now(), sq) / 2);
    endfunction

    function automatic bit offer_duty(longint w1, longint w2);
        longint d1;
        longint d2;
        longint c;
        d1 = sat_32(w1);
        d2 = sat_32(w2);
        if (!duty_feasible(d1, d2))
            return 1'b0;
        c = lagrangian(d1, d2);
        if (c < cost_floor)
        begin
            cost_floor = c;
            pick0 = d1;
            pick1 = d2;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // One ADMM iteration: candidate search, then averages and multipliers.
    function automatic void admm_iteration(longint cp0, longint cp1);
        longint rho;
        longint m;
        longint n;
        longint z1;
        longint z2;
        longint u1;
        longint u2;
        longint ol;
        longint t;
        longint base;
        longint up;
        bit     dummy;
        rho = rho_now();
        m  = q_add(q_mul(k_own, k_own), q_mul(k_other, k_other));
        n  = q_mul(k_other, k_other);
        z1 = q_sub(q_sub(q_mul(rho, avg0), e_cost), lam0);
        z2 = q_sub(q_mul(rho, avg1), lam1);
        u1 = q_div(z1, rho);
        u2 = q_div(z2, rho);
        ol = q_sub(ext_h, tgt_h);
        cost_floor = Q_CEIL;
        if (!offer_duty(u1, u2))
        begin
            dummy = offer_duty(0, u2);
            dummy = offer_duty(Q_HUNDRED, u2);
            if (m > 0)
            begin
                t = q_add(ol, q_div(q_add(q_mul(k_own, z1), q_mul(k_other, z2)), rho));
                dummy = offer_duty(q_sub(u1, q_div(q_mul(k_own, t), m)),
                                   q_sub(u2, q_div(q_mul(k_other, t), m)));
            end
            if (n > 0)
            begin
                base  = q_add(q_mul(k_other, ol), q_div(q_mul(n, z2), rho));
                dummy = offer_duty(0, q_sub(u2, q_div(base, n)));
                up    = q_add(base, q_mul(q_mul(k_other, k_own), Q_HUNDRED));
                dummy = offer_duty(Q_HUNDRED, q_sub(u2, q_div(up, n)));
            end
        end
        avg0 = sat_32((pick0 + cp0) / 2);
        avg1 = sat_32((pick1 + cp1) / 2);
        lam0 = sat_32(q_add(lam0, q_mul(rho, q_sub(pick0, avg0))));
        lam1 = sat_32(q_add(lam1, q_mul(rho, q_sub(pick1, avg1))));
    endfunction

    function automatic duty_word_t predict_duty(plan_row_t r);
        duty_word_t w;
        longint     lux;
        lux = 0;
        case (r.kind)
            KIND_START:
            begin
                avg0  = sat_32((longint'(r.pv_own) + longint'(r.cp_own)) / 2);
                avg1  = sat_32((longint'(r.pv_other) + longint'(r.cp_other)) / 2);
                lam0  = 0;
                lam1  = 0;
                ext_h = r.ext;
                tgt_h = lux_target;
            end
            KIND_ITER:
                admm_iteration(r.cp_own, r.cp_other);
            KIND_FINISH:
            begin
                if (upper_hit)
                begin
                    pick0 = Q_HUNDRED;
                    pick1 = Q_HUNDRED;
                end
                lux = sat_32(q_mul(k_own, pick0));
            end
            default:
                ;
        endcase
        w.own   = pick0[31:0];
        w.other = pick1[31:0];
        w.over  = upper_hit;
        w.lux   = lux[31:0];
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: bursts of words separated by random gaps.
    // ------------------------------------------------------------------------
    int burst_left;

    task automatic send_word(plan_row_t r);
        duty_word_t w;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {r.ext, r.pv_other, r.pv_own, r.cp_other, r.cp_own};
        do
            @(posedge clk);
        while (!s_axis_tready);
        w = predict_duty(r);
        // Rows with a hand-written expectation are checked against it directly.
        duty_pending.push_back(r.typed ? r.want : w);
        words_sent++;
    endtask

    // Configuration is only written with the unit idle. Every word yields a
    // result, so once nothing is pending the sequencer has gone quiet.
    task automatic write_registers(longint g0, longint g1, longint rh, longint ec,
                                   longint tg);
        longint vals[5];
        vals = '{g0, g1, rh, ec, tg};
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        wait (duty_pending.size() == 0);
        repeat (20) @(posedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i][30:0];
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        k_own      = vals[REG_GAIN_OWN] & 64'h7FFF_FFFF;
        k_other    = vals[REG_GAIN_OTHER] & 64'h7FFF_FFFF;
        rho_cfg    = vals[REG_PENALTY] & 64'h7FFF_FFFF;
        e_cost     = vals[REG_ENERGY] & 64'h7FFF_FFFF;
        lux_target = vals[REG_TARGET] & 64'h7FFF_FFFF;
    endtask

    function automatic logic signed [31:0] plausible_duty();
        return $signed($urandom_range(0, 140 << 16)) - (20 <<< 16);
    endfunction

    // Random part of a phase: mostly whole dimming episodes (start, a few
    // iterations, finish) with believable values, plus raw noise words.
    task automatic random_traffic(int count);
        plan_row_t r;
        int        n_iter;
        r.typed = 1'b0;
        r.want  = '{0, 0, 0, 0};
        while (count > 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                r.kind     = 2'($urandom_range(0, 3));
                r.cp_own   = $urandom;
                r.cp_other = $urandom;
                r.pv_own   = $urandom;
                r.pv_other = $urandom;
                r.ext      = $urandom;
                send_word(r);
                count--;
            end
            else
            begin
                r.kind     = KIND_START;
                r.cp_own   = plausible_duty();
                r.cp_other = plausible_duty();
                r.pv_own   = plausible_duty();
                r.pv_other = plausible_duty();
                r.ext      = $urandom_range(0, 400 << 16);
                if ($urandom_range(0, 7) == 0)
                    r.ext = -$signed($urandom_range(0, 400 << 16));
                send_word(r);
                n_iter = $urandom_range(1, 6);
                for (int i = 0; i < n_iter; i++)
                begin
                    r.kind = KIND_ITER;
                    // The neighbour's copy drifts around the last chosen duty.
                    r.cp_own   = pick0[31:0] + $signed($urandom_range(0, 20 << 16))
                                 - (10 <<< 16);
                    r.cp_other = plausible_duty();
                    send_word(r);
                end
                r.kind = KIND_FINISH;
                send_word(r);
                count -= n_iter + 2;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready pattern that switches mode at random between always
    // ready, coin-toss ready and long stalls.
    // ------------------------------------------------------------------------
    int stall_mode;
    int stall_left;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(64, 512);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Result checker: every accepted word is matched to the oldest prediction.
    always @(posedge clk)
    begin
        duty_word_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_seen++;
            if (m_axis_tuser)
                over_seen++;
            if (duty_pending.size() == 0)
            begin
                $error("result word with nothing pending");
                errors++;
            end
            else
            begin
                w = duty_pending.pop_front();
                if (m_axis_tdata[31:0] !== w.own)
                begin
                    $error("duty_own: expected %0d, got %0d", w.own,
                           $signed(m_axis_tdata[31:0]));
                    errors++;
                end
                if (m_axis_tdata[63:32] !== w.other)
                begin
                    $error("duty_other: expected %0d, got %0d", w.other,
                           $signed(m_axis_tdata[63:32]));
                    errors++;
                end
                if (m_axis_tuser !== w.over)
                begin
                    $error("over_max: expected %0d, got %0d", w.over, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[95:64] !== w.lux)
                begin
                    $error("ref_lux: expected %0d, got %0d", w.lux,
                           $signed(m_axis_tdata[95:64]));
                    errors++;
                end
            end
        end
    end

    // Hard limit: several times the slowest legal run.
    initial
    begin
        #400_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        plan_row_t plan[$];
        plan_row_t r;
        int        per_phase;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_START;
        m_axis_tready = 1'b0;
        stall_mode    = 0;
        stall_left    = 0;
        errors        = 0;
        words_sent    = 0;
        words_seen    = 0;
        over_seen     = 0;
        burst_left    = 0;
        // Predictor reset, matching the unit's register reset values.
        k_own = Q_ONE; k_other = 0; rho_cfg = Q_ONE; e_cost = Q_ONE; lux_target = 0;
        avg0 = 0; avg1 = 0; lam0 = 0; lam1 = 0; pick0 = 0; pick1 = 0;
        ext_h = 0; tgt_h = 0; upper_hit = 1'b0; cost_floor = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset register values. Straight after reset
        // the outputs are all zero, and an unknown kind changes nothing.
        plan.push_back('{KIND_START, 0, 0, 0, 0, 0, 1'b1, '{0, 0, 0, 0}});
        plan.push_back('{KIND_FINISH, 0, 0, 0, 0, 0, 1'b1, '{0, 0, 0, 0}});
        plan.push_back('{KIND_UNKNOWN, -1, -1, -1, -1, -1, 1'b1, '{0, 0, 0, 0}});
        // A believable episode around half power.
        plan.push_back('{KIND_START, 50 << 16, 40 << 16, 50 << 16, 40 << 16,
                         20 << 16, 1'b0, '{0, 0, 0, 0}});
        for (int i = 0; i < 4; i++)
            plan.push_back('{KIND_ITER, 45 << 16, 42 << 16, 0, 0, 0, 1'b0,
                             '{0, 0, 0, 0}});
        plan.push_back('{KIND_FINISH, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0, 0}});
        // Averages far above full power: the upper dimming bound trips and the
        // finish word forces both duties to 100.
        plan.push_back('{KIND_START, 300 << 16, 300 << 16, 300 << 16, 300 << 16,
                         0, 1'b0, '{0, 0, 0, 0}});
        plan.push_back('{KIND_ITER, 300 << 16, 300 << 16, 0, 0, 0, 1'b0,
                         '{0, 0, 0, 0}});
        plan.push_back('{KIND_FINISH, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0, 0}});
        // Field extremes: averages and multipliers saturate.
        plan.push_back('{KIND_START, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '{0, 0, 0, 0}});
        plan.push_back('{KIND_ITER, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 1'b0,
                         '{0, 0, 0, 0}});
        plan.push_back('{KIND_ITER, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 1'b0,
                         '{0, 0, 0, 0}});
        plan.push_back('{KIND_START, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '{0, 0, 0, 0}});
        plan.push_back('{KIND_ITER, -1, -1, 0, 0, 0, 1'b0, '{0, 0, 0, 0}});
        plan.push_back('{KIND_FINISH, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0, 0}});
        plan.push_back('{KIND_UNKNOWN, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0, 0}});
        foreach (plan[i])
            send_word(plan[i]);

        per_phase = (RUN_ITEMS - plan.size()) / N_PHASES;
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0: ;  // reset values
                // Two lamps coupled, small penalty, a real lux target.
                1: write_registers(2 << 16, 32768, 4588, Q_ONE, 150 << 16);
                // Every register at its top value.
                2: write_registers(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
                // All zero: both divisors vanish and the penalty falls back to
                // its smallest step.
                3: write_registers(0, 0, 0, 0, 0);
                // No neighbour coupling, so the corner candidates drop out.
                4: write_registers(98304, 0, Q_ONE, 32768, 80 << 16);
                // Smallest legal penalty with a demanding target.
                5: write_registers(Q_ONE, Q_ONE, 1, Q_ONE, 250 << 16);
                6: write_registers($urandom_range(0, 5 << 16), $urandom_range(0, 3 << 16),
                                   $urandom_range(1, 2 << 16), $urandom_range(0, 2 << 16),
                                   $urandom_range(0, 300 << 16));
                default: write_registers($urandom, $urandom, $urandom_range(1, 32'h7FFF_FFFF),
                                         $urandom, $urandom);
            endcase
            random_traffic(per_phase);
        end

        s_axis_tvalid <= 1'b0;
        wait (duty_pending.size() == 0);
        repeat (200) @(posedge clk);
        if (duty_pending.size() != 0)
        begin
            $error("%0d result words never arrived", duty_pending.size());
            errors++;
        end
        $display("Covered %0d words in %0d register settings; %0d results returned,",
                 words_sent, N_PHASES, words_seen);
        $display("%0d of them flagged the upper dimming bound; %0d mismatches.",
                 over_seen, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/acds_pkg.sv
rtl/acds_mdu.sv
rtl/admm_consensus_duty_step_unit.sv
bench/testbench.sv
